### sv/ilie_pkg.sv
// Shared types and codes for the indexed list insert/erase core.
package ilie_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int WORD_W       = 32;
  localparam int POS_W        = 5;
  localparam int LEN_W        = 9;

  localparam logic [3:0] REQ_READ   = 4'd0;
  localparam logic [3:0] REQ_WRITE  = 4'd1;
  localparam logic [3:0] REQ_INSERT = 4'd2;
  localparam logic [3:0] REQ_ERASE  = 4'd3;
  localparam logic [3:0] REQ_PUSH   = 4'd4;
  localparam logic [3:0] REQ_POP    = 4'd5;
  localparam logic [3:0] REQ_CLEAR  = 4'd6;
  localparam logic [3:0] REQ_RESIZE = 4'd7;
  localparam logic [3:0] REQ_ASSIGN = 4'd8;
  localparam logic [3:0] REQ_FRONT  = 4'd9;
  localparam logic [3:0] REQ_BACK   = 4'd10;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_FILL   = 2'd1,
    CELL_INSERT = 2'd2,
    CELL_ERASE  = 2'd3
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t         mode;
    logic [LEN_W-1:0]   lo;
    logic [LEN_W-1:0]   hi;
    logic [WORD_W-1:0]  word;
  } cell_cmd_t;

endpackage

### sv/ilie_req_if.sv
// Request channel: valid/ready handshake with request payload.
interface ilie_req_if;
  logic                               valid;
  logic                               ready;
  logic [3:0]                         req_type;
  logic [ilie_pkg::POS_W-1:0]         position;
  logic signed [ilie_pkg::WORD_W-1:0] word_in;

  modport source (output valid, req_type, position, word_in, input ready);
  modport sink   (input valid, req_type, position, word_in, output ready);
endinterface

### sv/ilie_rsp_if.sv
// Response channel: valid/ready handshake with result payload.
interface ilie_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [ilie_pkg::WORD_W-1:0] word_out;
  logic [1:0]                         status;
  logic [ilie_pkg::POS_W-1:0]         length;

  modport source (output valid, word_out, status, length, input ready);
  modport sink   (input valid, word_out, status, length, output ready);
endinterface

### sv/ilie_cell.sv
// One list slot: holds a word and takes a fill, its lower or its upper neighbor.
module ilie_cell #(
  parameter int IDX = 0
) (
  input  logic                          clk,
  input  ilie_pkg::cell_cmd_t           cmd,
  input  logic [ilie_pkg::WORD_W-1:0]   lower_i,
  input  logic [ilie_pkg::WORD_W-1:0]   upper_i,
  output logic [ilie_pkg::WORD_W-1:0]   val_o
);

  localparam logic [ilie_pkg::LEN_W-1:0] MY   = ilie_pkg::LEN_W'(IDX);
  localparam logic [ilie_pkg::LEN_W-1:0] MY_1 = ilie_pkg::LEN_W'(IDX + 1);

  logic [ilie_pkg::WORD_W-1:0] val_r;
  logic [ilie_pkg::WORD_W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    unique case (cmd.mode)
      ilie_pkg::CELL_FILL: begin
        if (MY >= cmd.lo && MY < cmd.hi) val_nxt = cmd.word;
      end
      ilie_pkg::CELL_INSERT: begin
        if (MY == cmd.lo) val_nxt = cmd.word;
        else if (MY > cmd.lo && MY <= cmd.hi) val_nxt = lower_i;
      end
      ilie_pkg::CELL_ERASE: begin
        if (MY >= cmd.lo && MY_1 < cmd.hi) val_nxt = upper_i;
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val_o = val_r;

endmodule

### sv/indexed_list_insert_erase_core.sv
// Indexed list core: a row of word cells that shift or fill together per request.
// A result beat is registered on the edge that accepts its request beat.
// Throughput: one request per cycle unless stalled; all cells update together.
// Reset: clears the count and the result valid; cell contents stay undefined.
// A request is taken whenever no result waits or the waiting one is taken.
module indexed_list_insert_erase_core #(
  parameter int CAPACITY = ilie_pkg::CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ilie_req_if.sink   in_req,
  ilie_rsp_if.source out_rsp
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam logic [ilie_pkg::LEN_W-1:0] CAP = ilie_pkg::LEN_W'(CAPACITY);

  logic [CW-1:0]                 cnt_r;
  logic [CW-1:0]                 cnt_nxt;
  logic                          out_valid_r;
  logic [ilie_pkg::WORD_W-1:0]   word_r;
  logic [1:0]                    status_r;
  logic [ilie_pkg::POS_W-1:0]    len_r;

  logic                          accept;
  ilie_pkg::cell_cmd_t           cmd;
  logic [1:0]                    status;
  logic                          rd_en;
  logic [ilie_pkg::LEN_W-1:0]    rd_idx;
  logic [ilie_pkg::LEN_W-1:0]    pos_x;
  logic [ilie_pkg::LEN_W-1:0]    cnt_x;
  logic [ilie_pkg::WORD_W-1:0]   rd_word;
  logic [ilie_pkg::WORD_W-1:0]   elem [CAPACITY];

  assign in_req.ready = !out_valid_r || out_rsp.ready;
  assign accept       = in_req.valid && in_req.ready;
  assign pos_x        = ilie_pkg::LEN_W'(in_req.position);
  assign cnt_x        = ilie_pkg::LEN_W'(cnt_r);

  always_comb begin
    cmd.mode = ilie_pkg::CELL_HOLD;
    cmd.lo   = pos_x;
    cmd.hi   = cnt_x;
    cmd.word = in_req.word_in;
    cnt_nxt  = cnt_r;
    status   = ilie_pkg::ST_OK;
    rd_en    = 1'b0;
    rd_idx   = pos_x;
    unique case (in_req.req_type)
      ilie_pkg::REQ_READ: begin
        if (pos_x < cnt_x) rd_en = 1'b1;
        else status = ilie_pkg::ST_RANGE;
      end
      ilie_pkg::REQ_WRITE: begin
        if (pos_x < cnt_x) begin
          cmd.mode = ilie_pkg::CELL_FILL;
          cmd.hi   = pos_x + 1'b1;
        end else begin
          status = ilie_pkg::ST_RANGE;
        end
      end
      ilie_pkg::REQ_INSERT: begin
        if (pos_x > cnt_x) status = ilie_pkg::ST_RANGE;
        else if (cnt_x >= CAP) status = ilie_pkg::ST_FULL;
        else begin
          cmd.mode = ilie_pkg::CELL_INSERT;
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      ilie_pkg::REQ_ERASE: begin
        if (pos_x >= cnt_x) status = ilie_pkg::ST_RANGE;
        else begin
          cmd.mode = ilie_pkg::CELL_ERASE;
          cnt_nxt  = cnt_r - 1'b1;
        end
      end
      ilie_pkg::REQ_PUSH: begin
        if (cnt_x >= CAP) status = ilie_pkg::ST_FULL;
        else begin
          cmd.mode = ilie_pkg::CELL_FILL;
          cmd.lo   = cnt_x;
          cmd.hi   = cnt_x + 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      ilie_pkg::REQ_POP: begin
        if (cnt_r == '0) status = ilie_pkg::ST_EMPTY;
        else cnt_nxt = cnt_r - 1'b1;
      end
      ilie_pkg::REQ_CLEAR: begin
        cnt_nxt = '0;
      end
      ilie_pkg::REQ_RESIZE: begin
        if (pos_x < cnt_x) cnt_nxt = CW'(pos_x);
        else if (pos_x > cnt_x) begin
          if (pos_x > CAP) status = ilie_pkg::ST_FULL;
          else begin
            cmd.mode = ilie_pkg::CELL_FILL;
            cmd.lo   = cnt_x;
            cmd.hi   = pos_x;
            cnt_nxt  = CW'(pos_x);
          end
        end
      end
      ilie_pkg::REQ_ASSIGN: begin
        if (pos_x > CAP) status = ilie_pkg::ST_FULL;
        else begin
          cmd.mode = ilie_pkg::CELL_FILL;
          cmd.lo   = '0;
          cmd.hi   = pos_x;
          cnt_nxt  = CW'(pos_x);
        end
      end
      ilie_pkg::REQ_FRONT: begin
        if (cnt_r == '0) status = ilie_pkg::ST_EMPTY;
        else begin
          rd_en  = 1'b1;
          rd_idx = '0;
        end
      end
      ilie_pkg::REQ_BACK: begin
        if (cnt_r == '0) status = ilie_pkg::ST_EMPTY;
        else begin
          rd_en  = 1'b1;
          rd_idx = cnt_x - 1'b1;
        end
      end
      default: status = ilie_pkg::ST_OK;
    endcase
    if (!accept) begin
      cmd.mode = ilie_pkg::CELL_HOLD;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ilie_pkg::WORD_W-1:0] lower;
    logic [ilie_pkg::WORD_W-1:0] upper;
    if (g == 0) begin : g_lo_edge
      assign lower = '0;
    end else begin : g_lo
      assign lower = elem[g-1];
    end
    if (g == CAPACITY - 1) begin : g_up_edge
      assign upper = '0;
    end else begin : g_up
      assign upper = elem[g+1];
    end
    ilie_cell #(.IDX(g)) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .lower_i (lower),
      .upper_i (upper),
      .val_o   (elem[g])
    );
  end

  assign rd_word = rd_en ? elem[rd_idx[IW-1:0]] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word_r   <= rd_word;
      status_r <= status;
      len_r    <= ilie_pkg::POS_W'(cnt_nxt);
    end
  end

  assign out_rsp.valid    = out_valid_r;
  assign out_rsp.word_out = word_r;
  assign out_rsp.status   = status_r;
  assign out_rsp.length   = len_r;

endmodule
